@@ hdl/srfi_pkg.sv @@
package srfi_pkg;

  localparam int unsigned ValW   = 48;
  localparam int unsigned ParW   = 16;
  localparam int unsigned RndW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // divide by 100 in the lanes: 16-bit digits, four steps over a 64-bit product
  localparam int unsigned DivChW   = 16;
  localparam int unsigned DivSteps = 4;

  typedef enum logic [2:0] {
    FAULT_NONE       = 3'd0,
    FAULT_DISCONNECT = 3'd1,
    FAULT_NOISE      = 3'd2,
    FAULT_ANOMALY    = 3'd3,
    FAULT_SPIKE      = 3'd4,
    FAULT_OFFSET     = 3'd5,
    FAULT_STUCK      = 3'd6,
    FAULT_NONE_ALT   = 3'd7
  } fault_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_IOERR   = 2'd2,
    ST_READERR = 2'd3
  } status_e;

  localparam logic [CfgIdxW-1:0] REG_FAULT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PA    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PB    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PC    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PD    = 3'd4;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_TRIPLE = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_DECIDE, S_MUL, S_DIV, S_OUT
  } state_e;

  // lane control from sequencer
  typedef struct packed {
    logic               start;
    logic               step;
    logic               bypass;
    logic signed [17:0] num;
  } lane_ctl_t;

  typedef struct packed {
    logic [1:0]       status;
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] y;
    logic signed [ValW-1:0] z;
  } out_word_t;

  typedef struct packed {
    logic              read_ok;
    logic [1:0]        channel_kind;
    logic signed [ValW-1:0] value_x;
    logic signed [ValW-1:0] value_y;
    logic signed [ValW-1:0] value_z;
    logic [RndW-1:0]   random_period;
    logic [RndW-1:0]   random_level;
  } in_word_t;

endpackage

@@ hdl/srfi_if.sv @@
interface srfi_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sensor_reading_fault_injector_unit.sv @@
// Channel   Dir  Handshake     Payload
// in_if     in   valid/ready   read_ok, channel_kind, value_x/y/z, random words
// out_if    out  valid/ready   status, out_x/y/z
// cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i
// An item goes from accept to the next accept through two 32-step remainder
// runs (period word, then level word), decide, four divide-by-100 steps, the
// output load and the return to idle. Reset clears all counters, targets,
// stuck state and control registers, not the data registers. A full output
// register holds its word and stalls the item in the divide state.
module sensor_reading_fault_injector_unit
  import srfi_pkg::*;
#(
  parameter int unsigned AXES = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  srfi_if.sink               in_if,
  srfi_if.source             out_if
);
  fault_e          fault_q;
  logic [ParW-1:0] pa_q, pb_q, pc_q, pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= FAULT_NONE;
      pa_q <= '0; pb_q <= '0; pc_q <= '0; pd_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FAULT: fault_q <= fault_e'(cfg_data_i[2:0]);
        REG_PA:    pa_q <= cfg_data_i;
        REG_PB:    pb_q <= cfg_data_i;
        REG_PC:    pc_q <= cfg_data_i;
        REG_PD:    pd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e   state_q, state_d;
  in_word_t item_q;
  logic [ParW-1:0] dc_q, dt_q, asc_q, ast_q, atc_q, att_q;
  logic [ParW-1:0] dc_d, dt_d, asc_d, ast_d, atc_d, att_d;
  logic            stuck_q, stuck_d;
  logic signed [ValW-1:0] sv_q [3];
  logic            sv_cap, sv_clr;
  logic [1:0]      status_q, status_d;
  logic [2:0]      nax_q, nax_d;
  logic [1:0]      dstep_q, dstep_d;
  lane_ctl_t       ctl;
  logic            mod_start, mod_done;
  logic [RndW-1:0] mod_num;
  logic [ParW:0]   mod_den, rem_period, rem_level;
  logic [ParW:0]   rem_p_q;
  logic            mod_phase_q, mod_phase_d;
  out_word_t       out_q;
  logic            out_v_q;
  logic signed [ValW-1:0] lane_out [3];
  logic signed [ValW-1:0] lane_in [3];

  wire triple = item_q.channel_kind == KIND_TRIPLE;
  wire sup    = item_q.channel_kind[1] == 1'b0;
  wire ab_bad = pa_q > pb_q;
  wire cd_bad = pc_q > pd_q;
  wire is_none = fault_q == FAULT_NONE || fault_q == FAULT_NONE_ALT;

  // remainder unit: period word started at accept, then level word
  assign mod_num = (state_q == S_IDLE) ? in_if.data.random_period : item_q.random_level;
  assign mod_den = (state_q == S_IDLE || fault_q != FAULT_ANOMALY)
                 ? {1'b0, pb_q} - {1'b0, pa_q} + 1'b1
                 : {1'b0, pd_q} - {1'b0, pc_q} + 1'b1;

  srfi_mod u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .num_i(mod_num), .den_i(mod_den),
    .done_o(mod_done), .rem_o(rem_period)
  );
  assign rem_level = rem_period;

  // period counter step
  function automatic logic [2*ParW:0] step_cnt(input logic [ParW-1:0] c,
                                               input logic [ParW-1:0] t,
                                               input logic [ParW-1:0] drawn);
    logic [ParW-1:0] tt;
    tt = (t == '0) ? drawn : t;
    if (c < tt) step_cnt = {1'b0, c + 1'b1, tt};
    else        step_cnt = {1'b1, {ParW{1'b0}}, {ParW{1'b0}}};
  endfunction

  logic [ParW-1:0] drawn_p, level_pct;
  logic [2*ParW:0] sc;
  logic            fire;
  logic signed [17:0] num_calc;

  always_comb begin
    drawn_p   = rem_p_q[ParW-1:0] + pa_q;
    level_pct = rem_level[ParW-1:0] +
                ((fault_q == FAULT_ANOMALY) ? pc_q : pa_q);
    sc = '0;
    fire = 1'b0;
    state_d = state_q;
    mod_start = 1'b0;
    mod_phase_d = mod_phase_q;
    dc_d = dc_q; dt_d = dt_q; asc_d = asc_q; ast_d = ast_q;
    atc_d = atc_q; att_d = att_q;
    stuck_d = stuck_q;
    sv_cap = 1'b0; sv_clr = 1'b0;
    status_d = status_q;
    nax_d = nax_q;
    dstep_d = dstep_q;
    ctl.start = 1'b0; ctl.step = 1'b0; ctl.bypass = 1'b1; ctl.num = 18'sd100;
    num_calc = 18'sd100;
    case (state_q)
      S_IDLE: if (in_if.valid && in_if.ready) begin
        state_d = S_MOD; mod_start = 1'b1; mod_phase_d = 1'b0;
      end
      S_MOD: if (mod_done) begin
        if (!mod_phase_q) begin
          mod_start = 1'b1; mod_phase_d = 1'b1;
        end else state_d = S_DECIDE;
      end
      S_DECIDE: begin
        status_d = ST_OK;
        nax_d = triple ? 3'(AXES) : 3'd1;
        if (is_none) begin
          stuck_d = 1'b0; sv_clr = 1'b1;
          if (!item_q.read_ok) status_d = ST_READERR;
        end else if (!item_q.read_ok) status_d = ST_READERR;
        else if (fault_q == FAULT_DISCONNECT) begin
          if (ab_bad) status_d = ST_INVALID;
          else begin
            sc = step_cnt(dc_q, dt_q, drawn_p);
            {fire, dc_d, dt_d} = sc;
            if (fire) status_d = ST_IOERR;
          end
        end else if (!sup) status_d = ST_INVALID;
        else if (fault_q == FAULT_NOISE) begin
          if (ab_bad) status_d = ST_INVALID;
          else begin
            ctl.bypass = 1'b0;
            num_calc = 18'sd100 + $signed({2'b0, level_pct});
          end
        end else if (fault_q == FAULT_ANOMALY) begin
          if (ab_bad || cd_bad) status_d = ST_INVALID;
          else begin
            if (triple) begin
              sc = step_cnt(atc_q, att_q, drawn_p);
              {fire, atc_d, att_d} = sc;
            end else begin
              sc = step_cnt(asc_q, ast_q, drawn_p);
              {fire, asc_d, ast_d} = sc;
            end
            ctl.bypass = !fire;
            num_calc = 18'sd100 + $signed({2'b0, level_pct});
          end
        end else if (fault_q == FAULT_OFFSET) begin
          if (pb_q == '0) status_d = ST_INVALID;
          else begin
            ctl.bypass = 1'b0;
            num_calc = (pa_q != '0) ? 18'sd100 - $signed({2'b0, pb_q})
                                    : 18'sd100 + $signed({2'b0, pb_q});
          end
        end else if (fault_q == FAULT_STUCK) begin
          if (!stuck_q) begin stuck_d = 1'b1; sv_cap = 1'b1; end
        end
        ctl.num = num_calc;
        ctl.start = 1'b1;
        dstep_d = '0;
        state_d = S_MUL;
      end
      // lanes take one quotient digit per cycle
      S_MUL: begin
        ctl.step = 1'b1;
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == 2'(DivSteps - 1)) state_d = S_DIV;
      end
      S_DIV: if (!out_v_q || out_if.ready) state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // lanes
  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign lane_in[g] = (g == 0) ? item_q.value_x :
                        (g == 1) ? item_q.value_y : item_q.value_z;
    srfi_lane u_lane (
      .clk_i, .rst_ni, .ctl_i(ctl), .val_i(lane_in[g]), .val_o(lane_out[g])
    );
  end

  wire stuck_sel = fault_q == FAULT_STUCK;
  wire take_out  = state_q == S_DIV && (!out_v_q || out_if.ready);

  // merge lanes into result word
  function automatic logic signed [ValW-1:0] pick(input int unsigned i,
      input logic signed [ValW-1:0] v, input logic signed [ValW-1:0] s,
      input logic [1:0] st, input logic [2:0] n, input logic use_s);
    pick = (st != ST_OK || 3'(i) >= n) ? '0 : (use_s ? s : v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mod_phase_q <= 1'b0;
      dc_q <= '0; dt_q <= '0; asc_q <= '0; ast_q <= '0; atc_q <= '0; att_q <= '0;
      stuck_q <= 1'b0; out_v_q <= 1'b0; status_q <= ST_OK; nax_q <= 3'd1;
      dstep_q <= '0;
      sv_q[0] <= '0; sv_q[1] <= '0; sv_q[2] <= '0;
    end else begin
      state_q <= state_d; mod_phase_q <= mod_phase_d;
      dc_q <= dc_d; dt_q <= dt_d; asc_q <= asc_d; ast_q <= ast_d;
      atc_q <= atc_d; att_q <= att_d;
      stuck_q <= stuck_d; status_q <= status_d; nax_q <= nax_d;
      dstep_q <= dstep_d;
      if (sv_clr) begin
        sv_q[0] <= '0; sv_q[1] <= '0; sv_q[2] <= '0;
      end else if (sv_cap) begin
        sv_q[0] <= item_q.value_x;
        if (triple && AXES > 1) sv_q[1] <= item_q.value_y;
        if (triple && AXES > 2) sv_q[2] <= item_q.value_z;
      end
      if (take_out) out_v_q <= 1'b1;
      else if (out_if.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) item_q <= in_if.data;
    if (state_q == S_MOD && mod_done && !mod_phase_q) rem_p_q <= rem_period;
    if (take_out) begin
      out_q.status <= status_q;
      out_q.x <= pick(0, lane_out[0], sv_q[0], status_q, nax_q, stuck_sel);
      out_q.y <= pick(1, lane_out[1], sv_q[1], status_q, nax_q, stuck_sel);
      out_q.z <= pick(2, lane_out[2], sv_q[2], status_q, nax_q, stuck_sel);
    end
  end

  assign in_if.ready  = state_q == S_IDLE;
  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

  out_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_if.ready |=> out_v_q) else $error("result dropped");
  one_item_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> state_q == S_MOD) else $error("bad start");
  err_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.status != ST_OK |-> out_q.x == '0 && out_q.y == '0)
    else $error("error word carries data");
endmodule

@@ hdl/srfi_mod.sv @@
// Iterative r % m, one quotient bit per cycle (restoring).
module srfi_mod
  import srfi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RndW-1:0] num_i,
  input  logic [ParW:0]   den_i,
  output logic            done_o,
  output logic [ParW:0]   rem_o
);
  localparam int unsigned CntW = $clog2(RndW + 1);

  logic [RndW-1:0] num_q, num_d;
  logic [ParW+1:0] rem_q, rem_d;
  logic [ParW:0]   den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [ParW+1:0] trial;
  logic [ParW+1:0] step_rem;

  // one restoring step on the current remainder
  assign trial    = {rem_q[ParW:0], num_q[RndW-1]};
  assign step_rem = (trial >= {1'b0, den_q}) ? trial - {1'b0, den_q} : trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CntW'(RndW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[RndW-2:0], 1'b0};
      rem_d = step_rem;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // final remainder: from the last step while done, held afterwards
  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign rem_o  = busy_q ? step_rem[ParW:0] : rem_q[ParW:0];

  done_in_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (rem_q[ParW:0] < den_q || den_q == '0)) else $error("remainder out of range");
endmodule

@@ hdl/srfi_lane.sv @@
// One axis: value * num / 100, truncated toward zero, saturated; the value unchanged in bypass.
module srfi_lane
  import srfi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lane_ctl_t              ctl_i,
  input  logic signed [ValW-1:0] val_i,
  output logic signed [ValW-1:0] val_o
);
  localparam logic [ValW-1:0] MaxPos = {1'b0, {(ValW-1){1'b1}}};
  localparam int unsigned PW = DivChW * DivSteps;
  // floor(y / 25) = (y * Recip25) >> 26 for y below 2^21
  localparam logic [21:0] Recip25 = 22'd2684355;

  logic [ValW-1:0] mag_v;
  logic [16:0]     mag_n;
  logic            neg_q, byp_q;
  logic [PW-1:0]   acc_q;
  logic [6:0]      rem_q;
  logic [DivChW+6:0] part;
  logic [42:0]     qprod;
  logic [DivChW-1:0] qdig;
  logic [6:0]      rdig;
  logic [PW-1:0]   quot;
  logic [ValW-1:0] res;
  logic signed [ValW-1:0] hold_q;

  assign mag_v = val_i[ValW-1] ? ValW'(-val_i) : val_i;
  assign mag_n = ctl_i.num[17] ? 17'(-ctl_i.num) : ctl_i.num[16:0];

  // one long-division digit: (rem:top digit) / 100 as (x / 4) / 25
  assign part  = {rem_q, acc_q[PW-1 -: DivChW]};
  assign qprod = 43'(part[DivChW+6:2]) * 43'(Recip25);
  assign qdig  = qprod[26 +: DivChW];
  assign rdig  = 7'(part - 23'(qdig) * 23'd100);

  // start: magnitude product (48x17); step: shift in one quotient digit
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q  <= PW'(mag_v) * PW'(mag_n);
      rem_q  <= '0;
      neg_q  <= val_i[ValW-1] ^ ctl_i.num[17];
      byp_q  <= ctl_i.bypass;
      hold_q <= val_i;
    end else if (ctl_i.step) begin
      acc_q <= {acc_q[PW-DivChW-1:0], qdig};
      rem_q <= rdig;
    end
  end

  // saturate the quotient and apply the sign
  assign quot = acc_q;
  always_comb begin
    if (!neg_q) res = (quot > PW'(MaxPos)) ? MaxPos : quot[ValW-1:0];
    else if (quot >= PW'(MaxPos) + PW'(1)) res = ~MaxPos;
    else res = ValW'(-quot[ValW-1:0]);
  end
  assign val_o = byp_q ? hold_q : res;

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule
